/* rtl/sla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sla_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_CONSUME = 2'd1,
    OP_READ    = 2'd2,
    OP_READ_X  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_STORED   = 3'd0,
    EV_BUSY     = 3'd1,
    EV_DONE     = 3'd2,
    EV_OVERFLOW = 3'd3,
    EV_SKIPPED  = 3'd4,
    EV_EMPTY    = 3'd5,
    EV_READ     = 3'd6,
    EV_CONSUMED = 3'd7
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [5:0] len;
    logic       rdy;
    logic       rd_hit;
  } res_meta_t;

endpackage

`default_nettype wire

/* rtl/sla_line_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sla_line_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/serial_line_assembler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Serial line assembler. Each input word carries one operation in in_tuser: a received
// byte is appended to a line store of LINE_DEPTH bytes, a line feed or carriage return closes
// a non-empty line (zero terminator written, count cleared, message-ready raised), a consume
// clears message-ready and a read returns one store byte. Every word yields exactly one result
// word, whose event code travels in out_tuser. A new word is taken every cycle while the
// output is not held by out_tready; each result passes the line store read register and the
// stage-one register, then the output register. The store reads as all zeros after reset
// with no clearing pass.
module serial_line_assembler_unit
  import sla_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // rx_byte[7:0], read_index[13:8], zero[15:14]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // line_length[5:0], read_data[13:6],
                                       // message_ready[14], zero[15]
  output logic [2:0]       out_tuser   // event_res[2:0]
);

  localparam int LW = (LINE_AW > 6) ? LINE_AW : 6;

  logic [LINE_AW-1:0] fill_r, fill_nxt;
  logic               skip_r, skip_nxt;
  logic               pend_r, pend_nxt;
  logic [LINE_DEPTH-1:0] valid_r;

  logic       s1_vld_r;
  res_meta_t  s1_r, s1_nxt;
  logic       out_vld_r;
  event_t     out_ev_r;
  logic [5:0] out_len_r;
  logic [7:0] out_data_r;
  logic       out_rdy_r;

  logic        accept, s1_adv;
  op_t         op;
  logic [7:0]  ch;
  logic [5:0]  idx;
  logic        is_eol, in_range;
  logic [LW-1:0] idx_ext;
  logic [LINE_AW-1:0] raddr;
  logic        we, re;
  logic [7:0]  wdata;
  logic [7:0]  ram_q;
  logic [LINE_AW-1:0] len_sel;
  logic [LW-1:0] len_ext;

  assign op       = op_t'(in_tuser);
  assign ch       = in_tdata[7:0];
  assign idx      = in_tdata[13:8];
  assign is_eol   = (ch == CH_LF) || (ch == CH_CR);
  assign idx_ext  = LW'(idx);
  assign raddr    = idx_ext[LINE_AW-1:0];
  assign in_range = (9'(idx) < 9'(LINE_DEPTH));

  assign s1_adv    = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    fill_nxt  = fill_r;
    skip_nxt  = skip_r;
    pend_nxt  = pend_r;
    we        = 1'b0;
    re        = 1'b0;
    wdata     = ch;
    s1_nxt.ev = EV_READ;
    s1_nxt.rd_hit = 1'b0;
    len_sel   = fill_r;
    case (op)
      OP_BYTE: begin
        if (pend_r) begin
          skip_nxt  = 1'b1;
          s1_nxt.ev = EV_BUSY;
        end else if (is_eol) begin
          skip_nxt = 1'b0;
          if (fill_r == '0) begin
            s1_nxt.ev = EV_EMPTY;
          end else begin
            we        = 1'b1;
            wdata     = 8'd0;
            fill_nxt  = '0;
            pend_nxt  = 1'b1;
            s1_nxt.ev = EV_DONE;
          end
        end else if (fill_r >= LINE_AW'(LINE_DEPTH - 1)) begin
          skip_nxt  = 1'b1;
          fill_nxt  = '0;
          s1_nxt.ev = EV_OVERFLOW;
        end else if (skip_r) begin
          s1_nxt.ev = EV_SKIPPED;
        end else begin
          we        = 1'b1;
          fill_nxt  = fill_r + 1'b1;
          s1_nxt.ev = EV_STORED;
        end
      end
      OP_CONSUME: begin
        pend_nxt  = 1'b0;
        s1_nxt.ev = EV_CONSUMED;
      end
      default: begin
        re            = 1'b1;
        s1_nxt.ev     = EV_READ;
        s1_nxt.rd_hit = in_range && valid_r[raddr];
      end
    endcase
    if (s1_nxt.ev != EV_DONE) begin
      len_sel = fill_nxt;
    end
    len_ext    = LW'(len_sel);
    s1_nxt.len = len_ext[5:0];
    s1_nxt.rdy = pend_nxt;
  end

  sla_line_ram #(
    .DEPTH(LINE_DEPTH),
    .WIDTH(8)
  ) u_ram (
    .clk   (clk),
    .we    (accept && we),
    .waddr (fill_r),
    .wdata (wdata),
    .re    (accept && re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      skip_r    <= 1'b0;
      pend_r    <= 1'b0;
      valid_r   <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
        skip_r <= skip_nxt;
        pend_r <= pend_nxt;
        if (we) begin
          valid_r[fill_r] <= 1'b1;
        end
      end
      if (in_tready) begin
        s1_vld_r <= accept;
      end
      if (s1_adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv && s1_vld_r) begin
      out_ev_r   <= s1_r.ev;
      out_len_r  <= s1_r.len;
      out_rdy_r  <= s1_r.rdy;
      out_data_r <= s1_r.rd_hit ? ram_q : 8'd0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {1'b0, out_rdy_r, out_data_r, out_len_r};

  a_done_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_DONE) |-> out_tdata[14])
    else $error("line done without message ready");

  a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != EV_READ) |-> (out_tdata[13:6] == 8'd0))
    else $error("read data on a non-read event");

  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op == OP_BYTE) && pend_r |=> (s1_r.ev == EV_BUSY) && skip_r)
    else $error("byte while pending not dropped");

endmodule

`default_nettype wire
